// ----- rtl/core/tsdf_pkg.sv -----
package tsdf_pkg;

  // Grid geometry
  localparam int MAP_SIZE_LOG2 = 8;
  localparam int MAP_DIM       = 1 << MAP_SIZE_LOG2;
  localparam int ADDR_W        = 2 * MAP_SIZE_LOG2;
  localparam int MAP_CELLS     = 1 << ADDR_W;

  // Cell word: {distance Q9.4 signed, weight Q8.8}
  localparam int DIST_W = 13;
  localparam int WT_W   = 16;
  localparam int MEM_W  = DIST_W + WT_W;

  // Squared distance in 1/256 cell^2 and its root in sixteenths
  localparam int SQ_W   = 28;
  localparam int ROOT_W = SQ_W / 2;

  // Shared restoring divider
  localparam int DIV_N_W = 31;
  localparam int DIV_D_W = 17;
  localparam int DIV_Q_W = 14;

  // Stream widths
  localparam int S_TDATA_W = 96;
  localparam int M_TDATA_W = 48;
  localparam int CFG_W     = 12;

  typedef logic [1:0] cmd_t;

  localparam cmd_t CMD_INTEGRATE = 2'd0;
  localparam cmd_t CMD_READ      = 2'd1;
  localparam cmd_t CMD_WRITE     = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_START_OFF = 2'd1;
  localparam logic [1:0] ST_END_OFF   = 2'd2;

  localparam logic [1:0] CFG_TRUNC = 2'd0;
  localparam logic [1:0] CFG_FULLW = 2'd1;
  localparam logic [1:0] CFG_ROWS  = 2'd2;
  localparam logic [1:0] CFG_COLS  = 2'd3;

endpackage

// ----- rtl/core/tsdf_ray_integrator_top.sv -----
// TSDF ray integrator: fuses laser rays into a grid of signed distances/weights.
// Input stream (s_*): one transaction per command. s_tuser carries the command
// (integrate ray, read cell, write cell); s_tdata carries coordinates and cell
// load data. Output stream (m_*): exactly one result transaction per command.
// Config port: cfg_we/cfg_index/cfg_wdata; writing it only while the block idles
// is up to the user, the block itself has no check for it. Commands are
// processed one at a time. An integrate walks a Bresenham line; each cell off
// the map is only stepped over, each cell on the map runs the serial square
// root, two passes of the shared divider (ray weight, skipped when the weight
// is 0 or 1; blend, skipped when the summed weight is zero), plus the
// read-modify-write and stepping. A ray walks at most 512 cells.
// Reset: config returns to defaults, then a clearing pass zeroes all
// MAP_CELLS = 65536 entries of the cell memory one entry a cycle; s_tready
// stays low meanwhile, config writes are still taken.
// The output holds one result register: a new command is accepted while a
// result waits; if the receiver stalls, the next finished result waits in the
// engine until the register frees up.
module tsdf_ray_integrator_top (
  input  logic                           clk,
  input  logic                           rst,
  // s_tdata: robot_x[11:0] robot_y[23:12] hit_x[35:24] hit_y[47:36]
  //          cell_row[55:48] cell_col[63:56] load_distance[76:64]
  //          load_weight[92:77], zero pad [95:93]
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [tsdf_pkg::S_TDATA_W-1:0] s_tdata,
  // s_tuser: cmd[1:0]
  input  tsdf_pkg::cmd_t                 s_tuser,
  // m_tdata: status[1:0] cells_updated[12:2] cell_distance[25:13]
  //          cell_weight[41:26], zero pad [47:42]
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [tsdf_pkg::M_TDATA_W-1:0] m_tdata,
  input  logic                           cfg_we,
  input  logic [1:0]                     cfg_index,
  input  logic [tsdf_pkg::CFG_W-1:0]     cfg_wdata
);
  import tsdf_pkg::*;

  localparam logic [4:0] S_CLEAR = 5'd0;
  localparam logic [4:0] S_IDLE  = 5'd1;
  localparam logic [4:0] S_CMD   = 5'd2;
  localparam logic [4:0] S_RD    = 5'd3;
  localparam logic [4:0] S_RAY   = 5'd4;
  localparam logic [4:0] S_RAY2  = 5'd5;
  localparam logic [4:0] S_CELL  = 5'd6;
  localparam logic [4:0] S_SUM   = 5'd7;
  localparam logic [4:0] S_SQRT  = 5'd8;
  localparam logic [4:0] S_WGT   = 5'd9;
  localparam logic [4:0] S_WDIV  = 5'd10;
  localparam logic [4:0] S_MUL   = 5'd11;
  localparam logic [4:0] S_NUM   = 5'd12;
  localparam logic [4:0] S_BLEND = 5'd13;
  localparam logic [4:0] S_BDIV  = 5'd14;
  localparam logic [4:0] S_WR    = 5'd15;
  localparam logic [4:0] S_STEP  = 5'd16;
  localparam logic [4:0] S_DONE  = 5'd17;

  logic [4:0] state;

  // configuration
  logic [11:0] trunc_limit;
  logic [11:0] full_weight_limit;
  logic [8:0]  map_rows;
  logic [8:0]  map_cols;

  // latched command
  cmd_t               cmd;
  logic [11:0]        rx, ry, hx, hy;
  logic [ADDR_W-1:0]  addr;
  logic [DIST_W-1:0]  ld;
  logic [WT_W-1:0]    lw;

  // Bresenham walk
  logic signed [10:0] x0, y0, x1, y1;
  logic signed [11:0] dxb, dyb;
  logic signed [13:0] err;
  logic               sxn, syn;
  logic [10:0]        count;

  // per cell datapath
  logic [SQ_W-1:0]          ray2;
  logic [SQ_W-1:0]          sqa, sqb, sqc, sqd;
  logic                     front;
  logic [WT_W-1:0]          ow;
  logic signed [DIST_W-1:0] od;
  logic signed [DIST_W-1:0] sd;
  logic [8:0]               w;
  logic signed [29:0]       p1;
  logic signed [22:0]       p2;
  logic signed [30:0]       num;
  logic [DIV_D_W-1:0]       den;
  logic                     neg;
  logic signed [DIST_W-1:0] od_new;
  logic [WT_W-1:0]          wt_new;

  // result staging and output register
  logic [1:0]        res_status;
  logic [DIST_W-1:0] res_dist;
  logic [WT_W-1:0]   res_wt;
  logic [1:0]        out_status;
  logic [10:0]       out_cells;
  logic [DIST_W-1:0] out_dist;
  logic [WT_W-1:0]   out_wt;

  // cell memory
  logic [MEM_W-1:0]  mem [MAP_CELLS];
  logic [MEM_W-1:0]  mem_q;
  logic [ADDR_W-1:0] rd_addr;
  logic              mem_we;
  logic [ADDR_W-1:0] wr_addr;
  logic [MEM_W-1:0]  wr_data;
  logic [ADDR_W-1:0] clr_addr;

  // square root and shared divider
  logic                  sqrt_start, sqrt_done;
  logic [SQ_W-1:0]       sqrt_op;
  logic [ROOT_W-1:0]     root;
  logic                  div_start, div_done;
  logic [DIV_N_W-1:0]    div_n;
  logic [DIV_D_W-1:0]    div_d;
  logic [DIV_Q_W-1:0]    div_q;

  function automatic logic signed [10:0] trunc_q4(input logic signed [14:0] c);
    logic [14:0] mag;
    logic [10:0] q;
    mag = c[14] ? 15'(-c) : 15'(c);
    q   = 11'(mag >> 4);
    return c[14] ? $signed(-q) : $signed(q);
  endfunction

  // ---------------- combinational helpers ----------------
  logic [11:0]        rows_eff, cols_eff;
  logic               start_off, end_off;
  logic signed [14:0] c2x, c2y;
  logic signed [10:0] sx0, sy0, ex1, ey1;
  logic signed [11:0] ddx, ddy, adx, ady;
  logic               on_map;
  logic [ADDR_W-1:0]  cell_addr;
  logic signed [15:0] cx, cy, rx16, ry16, hx16, hy16;
  logic signed [15:0] ma, mb, mc, md;
  logic signed [31:0] pa, pb, pc, pd;
  logic [SQ_W-1:0]    hit2, rob2;
  logic [11:0]        dcl;
  logic signed [DIST_W-1:0] eps13, del13, gap;
  logic [11:0]        span;
  logic [20:0]        wnum;
  logic [30:0]        nmag;
  logic signed [14:0] e2;
  logic               stx, sty;

  assign rows_eff = ({3'b0, map_rows} > 12'(MAP_DIM)) ? 12'(MAP_DIM) : {3'b0, map_rows};
  assign cols_eff = ({3'b0, map_cols} > 12'(MAP_DIM)) ? 12'(MAP_DIM) : {3'b0, map_cols};
  assign start_off = ({4'b0, rx} > {cols_eff, 4'b0}) || ({4'b0, ry} > {rows_eff, 4'b0});
  assign end_off   = ({4'b0, hx} > {cols_eff, 4'b0}) || ({4'b0, hy} > {rows_eff, 4'b0});

  // end cell: 2*hit - robot in signed Q11.4, truncated toward zero
  assign c2x = $signed({2'b0, hx, 1'b0}) - $signed({3'b0, rx});
  assign c2y = $signed({2'b0, hy, 1'b0}) - $signed({3'b0, ry});
  assign ex1 = trunc_q4(c2x);
  assign ey1 = trunc_q4(c2y);
  assign sx0 = $signed({3'b0, rx[11:4]});
  assign sy0 = $signed({3'b0, ry[11:4]});
  assign ddx = 12'(ex1) - 12'(sx0);
  assign ddy = 12'(ey1) - 12'(sy0);
  assign adx = ddx[11] ? -ddx : ddx;
  assign ady = ddy[11] ? -ddy : ddy;

  assign on_map = !x0[10] && !y0[10] && (12'($unsigned(x0)) < cols_eff)
                  && (12'($unsigned(y0)) < rows_eff);
  assign cell_addr = {y0[MAP_SIZE_LOG2-1:0], x0[MAP_SIZE_LOG2-1:0]};

  assign cx   = 16'($signed({x0, 4'b0}));
  assign cy   = 16'($signed({y0, 4'b0}));
  assign rx16 = $signed({4'b0, rx});
  assign ry16 = $signed({4'b0, ry});
  assign hx16 = $signed({4'b0, hx});
  assign hy16 = $signed({4'b0, hy});
  assign ma   = (state == S_RAY) ? (rx16 - hx16) : (cx - hx16);
  assign mb   = (state == S_RAY) ? (ry16 - hy16) : (cy - hy16);
  assign mc   = cx - rx16;
  assign md   = cy - ry16;
  assign pa   = ma * ma;
  assign pb   = mb * mb;
  assign pc   = mc * mc;
  assign pd   = md * md;
  assign hit2 = sqa + sqb;
  assign rob2 = sqc + sqd;

  assign dcl   = ({{(SQ_W-ROOT_W){1'b0}}, root} > SQ_W'(trunc_limit)) ? trunc_limit
                                                                     : root[11:0];
  assign eps13 = $signed({1'b0, full_weight_limit});
  assign del13 = $signed({1'b0, trunc_limit});
  assign gap   = del13 - sd;
  assign span  = trunc_limit - full_weight_limit;
  assign wnum  = {1'b0, gap[11:0], 8'b0} + 21'(span >> 1);
  assign nmag  = num[30] ? 31'(-num) : 31'(num);
  assign wt_new = den[DIV_D_W-1] ? {WT_W{1'b1}} : den[WT_W-1:0];

  assign e2  = 15'(err) <<< 1;
  assign stx = e2 > 15'(dyb);
  assign sty = e2 < 15'(dxb);

  assign sqrt_start = (state == S_SUM);
  assign sqrt_op    = hit2;

  always_comb begin
    div_start = 1'b0;
    div_n     = DIV_N_W'(wnum);
    div_d     = DIV_D_W'(span);
    if (state == S_WGT) begin
      div_start = (sd > eps13) && (sd < del13);
    end else if (state == S_BLEND) begin
      div_start = (den != '0);
      div_n     = nmag + DIV_N_W'(den >> 1);
      div_d     = den;
    end
  end

  // memory ports
  assign rd_addr = (state == S_CELL) ? cell_addr : addr;

  always_comb begin
    mem_we  = 1'b0;
    wr_addr = cell_addr;
    wr_data = {od_new, wt_new};
    if (state == S_CLEAR) begin
      mem_we  = 1'b1;
      wr_addr = clr_addr;
      wr_data = '0;
    end else if (state == S_CMD && cmd == CMD_WRITE) begin
      mem_we  = 1'b1;
      wr_addr = addr;
      wr_data = {ld, lw};
    end else if (state == S_WR) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[wr_addr] <= wr_data;
    mem_q <= mem[rd_addr];
  end

  tsdf_sqrt u_sqrt (
    .clk     (clk),
    .rst     (rst),
    .start   (sqrt_start),
    .operand (sqrt_op),
    .root    (root),
    .done    (sqrt_done)
  );

  tsdf_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_n),
    .divisor  (div_d),
    .quotient (div_q),
    .done     (div_done)
  );

  // ---------------- configuration ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      trunc_limit       <= 12'd80;
      full_weight_limit <= 12'd16;
      map_rows          <= 9'd256;
      map_cols          <= 9'd256;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TRUNC: trunc_limit       <= cfg_wdata;
        CFG_FULLW: full_weight_limit <= cfg_wdata;
        CFG_ROWS:  map_rows          <= cfg_wdata[8:0];
        CFG_COLS:  map_cols          <= cfg_wdata[8:0];
        default:   ;
      endcase
    end
  end

  // ---------------- sequencer ----------------
  assign s_tready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      count    <= '0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + ADDR_W'(1);
          if (clr_addr == {ADDR_W{1'b1}}) state <= S_IDLE;
        end
        S_IDLE: begin
          if (s_tvalid) state <= S_CMD;
        end
        S_CMD: begin
          count <= '0;
          unique case (cmd)
            CMD_INTEGRATE: state <= (start_off || end_off) ? S_DONE : S_RAY;
            CMD_READ:      state <= S_RD;
            default:       state <= S_DONE;
          endcase
        end
        S_RD:    state <= S_DONE;
        S_RAY:   state <= S_RAY2;
        S_RAY2:  state <= S_CELL;
        S_CELL:  state <= on_map ? S_SUM : S_STEP;
        S_SUM:   state <= S_SQRT;
        S_SQRT:  if (sqrt_done) state <= S_WGT;
        S_WGT:   state <= div_start ? S_WDIV : S_MUL;
        S_WDIV:  if (div_done) state <= S_MUL;
        S_MUL:   state <= S_NUM;
        S_NUM:   state <= S_BLEND;
        S_BLEND: state <= div_start ? S_BDIV : S_WR;
        S_BDIV:  if (div_done) state <= S_WR;
        S_WR: begin
          count <= count + 11'd1;
          state <= S_STEP;
        end
        S_STEP: begin
          state <= ((x0 == x1) && (y0 == y1)) ? S_DONE : S_CELL;
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // output valid: set when a finished result moves in, cleared on handshake
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == S_DONE && (!m_tvalid || m_tready)) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // ---------------- datapath registers ----------------
  always_ff @(posedge clk) begin
    sqa <= pa[SQ_W-1:0];
    sqb <= pb[SQ_W-1:0];
    sqc <= pc[SQ_W-1:0];
    sqd <= pd[SQ_W-1:0];

    unique case (state)
      S_IDLE: begin
        cmd  <= s_tuser;
        rx   <= s_tdata[11:0];
        ry   <= s_tdata[23:12];
        hx   <= s_tdata[35:24];
        hy   <= s_tdata[47:36];
        addr <= {MAP_SIZE_LOG2'(s_tdata[55:48]), MAP_SIZE_LOG2'(s_tdata[63:56])};
        ld   <= s_tdata[76:64];
        lw   <= s_tdata[92:77];
      end
      S_CMD: begin
        res_dist   <= '0;
        res_wt     <= '0;
        res_status <= (cmd != CMD_INTEGRATE) ? ST_OK :
                      (start_off ? ST_START_OFF : (end_off ? ST_END_OFF : ST_OK));
        x0  <= sx0;
        y0  <= sy0;
        x1  <= ex1;
        y1  <= ey1;
        dxb <= adx;
        dyb <= -ady;
        sxn <= !(sx0 < ex1);
        syn <= !(sy0 < ey1);
        err <= 14'(adx) - 14'(ady);
      end
      S_RD: begin
        res_dist <= mem_q[MEM_W-1:WT_W];
        res_wt   <= mem_q[WT_W-1:0];
      end
      S_RAY2: ray2 <= hit2;
      S_SUM: begin
        front <= rob2 < ray2;
        ow    <= mem_q[WT_W-1:0];
        od    <= $signed(mem_q[MEM_W-1:WT_W]);
      end
      S_SQRT: begin
        if (sqrt_done) begin
          sd <= front ? -$signed({1'b0, dcl}) : $signed({1'b0, dcl});
        end
      end
      S_WGT: begin
        if (sd <= eps13)      w <= 9'd256;
        else if (sd >= del13) w <= 9'd0;
      end
      S_WDIV: if (div_done) w <= div_q[8:0];
      S_MUL: begin
        p1 <= $signed({1'b0, ow}) * od;
        p2 <= $signed({1'b0, w}) * sd;
      end
      S_NUM: begin
        num <= 31'(p1) + 31'(p2);
        den <= DIV_D_W'(ow) + DIV_D_W'(w);
      end
      S_BLEND: begin
        neg    <= num[30];
        od_new <= od;
      end
      S_BDIV: begin
        if (div_done) od_new <= neg ? -$signed(DIST_W'(div_q)) : $signed(DIST_W'(div_q));
      end
      S_STEP: begin
        err <= err + (stx ? 14'(dyb) : 14'sd0) + (sty ? 14'(dxb) : 14'sd0);
        if (stx) x0 <= sxn ? x0 - 11'sd1 : x0 + 11'sd1;
        if (sty) y0 <= syn ? y0 - 11'sd1 : y0 + 11'sd1;
      end
      S_DONE: begin
        if (!m_tvalid || m_tready) begin
          out_status <= res_status;
          out_cells  <= count;
          out_dist   <= res_dist;
          out_wt     <= res_wt;
        end
      end
      default: ;
    endcase
  end

  assign m_tdata = {6'b0, out_wt, out_dist, out_cells, out_status};

  // ---------------- assertions ----------------
  a_sqrt_done_owned: assert property (@(posedge clk) disable iff (rst)
    sqrt_done |-> state == S_SQRT)
    else $error("sqrt finished outside its wait state");

  a_div_done_owned: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_WDIV || state == S_BDIV))
    else $error("divider finished outside a wait state");

  a_weight_grows: assert property (@(posedge clk) disable iff (rst)
    state == S_WR |-> wt_new >= ow)
    else $error("accumulated weight decreased");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state) == S_DONE)
    else $error("result raised without a finished command");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= 11'd1024)
    else $error("cell count out of range");

endmodule

// ----- rtl/core/tsdf_sqrt.sv -----
module tsdf_sqrt (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [tsdf_pkg::SQ_W-1:0]   operand,
  output logic [tsdf_pkg::ROOT_W-1:0] root,
  output logic                        done
);
  import tsdf_pkg::*;

  localparam int CNT_W = $clog2(ROOT_W + 1);

  logic [SQ_W-1:0]  v;
  logic [SQ_W-1:0]  res;
  logic [SQ_W-1:0]  bitm;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [SQ_W-1:0]  trial;

  assign trial = res + bitm;
  assign root  = res[ROOT_W-1:0];

  // two result bits per pass would double the adder; one bit a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == CNT_W'(1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(ROOT_W);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      v    <= operand;
      res  <= '0;
      bitm <= SQ_W'(1) << (SQ_W - 2);
    end else if (busy) begin
      if (v >= trial) begin
        v   <= v - trial;
        res <= (res >> 1) + bitm;
      end else begin
        res <= res >> 1;
      end
      bitm <= bitm >> 2;
    end
  end

endmodule

// ----- rtl/core/tsdf_div.sv -----
module tsdf_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [tsdf_pkg::DIV_N_W-1:0] dividend,
  input  logic [tsdf_pkg::DIV_D_W-1:0] divisor,
  output logic [tsdf_pkg::DIV_Q_W-1:0] quotient,
  output logic                         done
);
  import tsdf_pkg::*;

  localparam int CNT_W = $clog2(DIV_Q_W + 1);

  logic [DIV_N_W-1:0] rem;
  logic [DIV_N_W-1:0] dsh;
  logic [CNT_W-1:0]   cnt;
  logic               busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == CNT_W'(1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DIV_Q_W);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) busy <= 1'b0;
      end
    end
  end

  // restoring, one quotient bit a cycle, MSB first
  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= dividend;
      dsh      <= DIV_N_W'(divisor) << (DIV_Q_W - 1);
      quotient <= '0;
    end else if (busy) begin
      if (rem >= dsh) begin
        rem      <= rem - dsh;
        quotient <= {quotient[DIV_Q_W-2:0], 1'b1};
      end else begin
        quotient <= {quotient[DIV_Q_W-2:0], 1'b0};
      end
      dsh <= dsh >> 1;
    end
  end

endmodule

// ----- test/tsdf_ray_integrator_top_tb.sv -----
`timescale 1ns / 100ps

module tsdf_ray_integrator_top_tb;
  import tsdf_pkg::*;

  localparam cmd_t CMD_UNUSED = 2'd3;

  // One command as it travels on the input stream
  typedef struct packed {
    cmd_t               cmd;
    logic [11:0]        rx;
    logic [11:0]        ry;
    logic [11:0]        hx;
    logic [11:0]        hy;
    logic [7:0]         row;
    logic [7:0]         col;
    logic signed [12:0] ld;
    logic [15:0]        lw;
  } ray_cmd_t;

  // One result transaction, laid out as m_tdata[41:0]
  typedef struct packed {
    logic [15:0]        wt;
    logic signed [12:0] cell_dist;
    logic [10:0]        cells;
    logic [1:0]         status;
  } cell_result_t;

  // Directed table row: either a register write or a command,
  // optionally with a hand-typed result
  typedef struct packed {
    logic         is_cfg;
    logic [1:0]   idx;
    logic [11:0]  val;
    ray_cmd_t     cmd;
    logic         typed;
    cell_result_t res;
  } dir_row_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;
  cmd_t                 s_tuser = CMD_INTEGRATE;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;
  logic                 cfg_we = 1'b0;
  logic [1:0]           cfg_index = CFG_TRUNC;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  tsdf_ray_integrator_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Shadow of the grid and the registers
  logic signed [12:0] dist_mem [MAP_CELLS];
  logic [15:0]        wt_mem   [MAP_CELLS];
  int                 trunc_lim, full_wt_lim, rows_reg, cols_reg;

  cell_result_t pending_q [$];
  int           err_cnt = 0;
  int           send_idle_pct = 0;
  int           recv_stall_pct = 0;
  int           recv_hold = 0;

  // ---------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------
  function automatic longint root_floor(longint v);
    longint r, b;
    r = 0;
    b = longint'(1) << 60;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Blend one signed distance into a cell, weighted average plus weight sum
  function automatic void blend_cell(int addr, longint sd);
    longint w, ow, od, num, den, span;
    if (sd <= full_wt_lim) begin
      w = 256;
    end else if (sd >= trunc_lim) begin
      w = 0;
    end else begin
      span = trunc_lim - full_wt_lim;
      w = ((trunc_lim - sd) * 256 + span / 2) / span;
    end
    ow = wt_mem[addr];
    od = dist_mem[addr];
    den = ow + w;
    if (den > 0) begin
      num = ow * od + w * sd;
      if (num >= 0) od = (num + den / 2) / den;
      else od = -((-num + den / 2) / den);
      dist_mem[addr] = od[12:0];
    end
    wt_mem[addr] = (den > 65535) ? 16'hFFFF : den[15:0];
  endfunction

  function automatic int q4_trunc(int c);
    return (c >= 0) ? (c >>> 4) : -((-c) >>> 4);
  endfunction

  // Walk the ray and fuse every on-map cell; returns cells updated
  function automatic int walk_ray(ray_cmd_t c, output logic [1:0] status);
    int     nrows, ncols, x0, y0, x1, y1, dx, dy, sx, sy, err, e2, count;
    longint rx, ry, hx, hy, ray2, cx, cy, d;
    nrows = (rows_reg > MAP_DIM) ? MAP_DIM : rows_reg;
    ncols = (cols_reg > MAP_DIM) ? MAP_DIM : cols_reg;
    rx = c.rx; ry = c.ry; hx = c.hx; hy = c.hy;
    count = 0;
    if (rx > ncols * 16 || ry > nrows * 16) begin
      status = ST_START_OFF;
      return 0;
    end
    if (hx > ncols * 16 || hy > nrows * 16) begin
      status = ST_END_OFF;
      return 0;
    end
    status = ST_OK;
    ray2 = (rx - hx) * (rx - hx) + (ry - hy) * (ry - hy);
    x0 = int'(rx) >>> 4;
    y0 = int'(ry) >>> 4;
    x1 = q4_trunc(2 * int'(hx) - int'(rx));
    y1 = q4_trunc(2 * int'(hy) - int'(ry));
    dx = (x1 > x0) ? x1 - x0 : x0 - x1;
    dy = -((y1 > y0) ? y1 - y0 : y0 - y1);
    sx = (x0 < x1) ? 1 : -1;
    sy = (y0 < y1) ? 1 : -1;
    err = dx + dy;
    forever begin
      if (x0 >= 0 && x0 < ncols && y0 >= 0 && y0 < nrows) begin
        cx = x0 * 16;
        cy = y0 * 16;
        d = root_floor((cx - hx) * (cx - hx) + (cy - hy) * (cy - hy));
        if (d > trunc_lim) d = trunc_lim;
        // in front of the hit point -> negative
        if ((cx - rx) * (cx - rx) + (cy - ry) * (cy - ry) < ray2) d = -d;
        blend_cell((y0 << MAP_SIZE_LOG2) | x0, d);
        count++;
      end
      if (x0 == x1 && y0 == y1) break;
      e2 = 2 * err;
      if (e2 > dy) begin
        err += dy;
        x0 += sx;
      end
      if (e2 < dx) begin
        err += dx;
        y0 += sy;
      end
    end
    return count;
  endfunction

  function automatic cell_result_t fuse_command(ray_cmd_t c);
    cell_result_t r;
    logic [1:0]   st;
    int           addr;
    r = '0;
    addr = {c.row, c.col};
    case (c.cmd)
      CMD_INTEGRATE: begin
        r.cells = walk_ray(c, st);
        r.status = st;
      end
      CMD_READ: begin
        r.cell_dist = dist_mem[addr];
        r.wt = wt_mem[addr];
      end
      CMD_WRITE: begin
        dist_mem[addr] = c.ld;
        wt_mem[addr] = c.lw;
      end
      default: ;
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------
  // Offer one command; s_tvalid stays high after the transaction so
  // back-to-back commands need no gap.
  task automatic send_cmd(ray_cmd_t c, logic typed, cell_result_t typed_res);
    cell_result_t r;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= c.cmd;
    s_tdata  <= {3'b000, c.lw, c.ld, c.col, c.row, c.hy, c.hx, c.ry, c.rx};
    do @(posedge clk); while (!s_tready);
    r = fuse_command(c);
    pending_q.insert(pending_q.size(), typed ? typed_res : r);
  endtask

  // Let the block go idle: all results in, plus a guard
  task automatic drain_block();
    @(negedge clk);
    s_tvalid <= 1'b0;
    wait (pending_q.size() == 0);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [11:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_TRUNC: trunc_lim   = val;
      CFG_FULLW: full_wt_lim = val;
      CFG_ROWS:  rows_reg    = val[8:0];
      default:   cols_reg    = val[8:0];
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Receiver: random stalls, plus a long hold-off when requested
  always @(negedge clk) begin
    if (recv_hold > 0) begin
      m_tready  <= 1'b0;
      recv_hold <= recv_hold - 1;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // ---------------------------------------------------------------
  // Result checker
  // ---------------------------------------------------------------
  always @(posedge clk) begin
    cell_result_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata[41:0];
      if (pending_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10)
          $display("%0t: result with nothing pending: %h", $realtime, got);
      end else begin
        want = pending_q.pop_front();
        if (got.status !== want.status || got.cells !== want.cells ||
            got.cell_dist !== want.cell_dist || got.wt !== want.wt) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("%0t: mismatch status %0d/%0d cells %0d/%0d dist %0d/%0d wt %0d/%0d",
                     $realtime, want.status, got.status, want.cells, got.cells,
                     want.cell_dist, got.cell_dist, want.wt, got.wt);
        end
      end
    end
  end

  // ---------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------
  function automatic ray_cmd_t mk_cmd(cmd_t cmd, int rx, int ry, int hx, int hy,
                                      int row, int col, int ld, int lw);
    ray_cmd_t c;
    c.cmd = cmd;
    c.rx = rx; c.ry = ry; c.hx = hx; c.hy = hy;
    c.row = row; c.col = col;
    c.ld = ld; c.lw = lw;
    return c;
  endfunction

  function automatic dir_row_t cmd_row(ray_cmd_t c);
    dir_row_t d;
    d = '0;
    d.cmd = c;
    return d;
  endfunction

  function automatic dir_row_t typed_row(ray_cmd_t c, int st, int cells, int cell_dist,
                                         int wt);
    dir_row_t d;
    d = cmd_row(c);
    d.typed = 1'b1;
    d.res.status = st;
    d.res.cells = cells;
    d.res.cell_dist = cell_dist;
    d.res.wt = wt;
    return d;
  endfunction

  function automatic dir_row_t cfg_row(logic [1:0] idx, int val);
    dir_row_t d;
    d = '0;
    d.is_cfg = 1'b1;
    d.idx = idx;
    d.val = val;
    return d;
  endfunction

  function automatic int clip12(int v);
    return (v < 0) ? 0 : ((v > 4095) ? 4095 : v);
  endfunction

  // Random command shaped by the current map size
  function automatic ray_cmd_t rand_cmd();
    ray_cmd_t c;
    int       p, nrows, ncols;
    nrows = (rows_reg > MAP_DIM) ? MAP_DIM : rows_reg;
    ncols = (cols_reg > MAP_DIM) ? MAP_DIM : cols_reg;
    c = '0;
    c.ld = $urandom;
    c.lw = $urandom;
    p = $urandom_range(99);
    if (p < 60) begin
      c.cmd = CMD_INTEGRATE;
      if ($urandom_range(9) == 0 && nrows <= 32 && ncols <= 32) begin
        // noise: anywhere, mostly off the map
        c.rx = $urandom; c.ry = $urandom; c.hx = $urandom; c.hy = $urandom;
      end else begin
        c.rx = clip12($urandom_range(ncols * 16));
        c.ry = clip12($urandom_range(nrows * 16));
        c.hx = clip12(int'(c.rx) + int'($urandom_range(96)) - 48);
        c.hy = clip12(int'(c.ry) + int'($urandom_range(96)) - 48);
      end
    end else begin
      c.cmd = (p < 80) ? CMD_READ : ((p < 95) ? CMD_WRITE : CMD_UNUSED);
      if ($urandom_range(3) == 0 || nrows == 0 || ncols == 0) begin
        c.row = $urandom;
        c.col = $urandom;
      end else begin
        // inside the map so reads see fused cells
        c.row = $urandom_range(nrows - 1);
        c.col = $urandom_range(ncols - 1);
      end
    end
    return c;
  endfunction

  dir_row_t dir_tbl [$];

  function automatic void add_row(dir_row_t d);
    dir_tbl.insert(dir_tbl.size(), d);
  endfunction

  initial begin
    int p, k, sel;
    for (int i = 0; i < MAP_CELLS; i++) begin
      dist_mem[i] = '0;
      wt_mem[i] = '0;
    end
    trunc_lim = 80;
    full_wt_lim = 16;
    rows_reg = 256;
    cols_reg = 256;

    // Directed: reset contents, load extremes, unused command, ray extremes,
    // off-map start/end, zero and oversized map, truncation extremes
    add_row(typed_row(mk_cmd(CMD_READ, 0, 0, 0, 0, 0, 0, 0, 0), ST_OK, 0, 0, 0));
    add_row(typed_row(mk_cmd(CMD_READ, 0, 0, 0, 0, 255, 255, 0, 0), ST_OK, 0, 0, 0));
    add_row(typed_row(mk_cmd(CMD_WRITE, 0, 0, 0, 0, 255, 255, -4096, 65535),
                      ST_OK, 0, 0, 0));
    add_row(typed_row(mk_cmd(CMD_READ, 0, 0, 0, 0, 255, 255, 0, 0),
                      ST_OK, 0, -4096, 65535));
    add_row(typed_row(mk_cmd(CMD_WRITE, 0, 0, 0, 0, 0, 0, 4095, 0), ST_OK, 0, 0, 0));
    add_row(typed_row(mk_cmd(CMD_READ, 0, 0, 0, 0, 0, 0, 0, 0), ST_OK, 0, 4095, 0));
    add_row(typed_row(mk_cmd(CMD_UNUSED, 4095, 4095, 4095, 4095, 0, 0, 77, 99),
                      ST_OK, 0, 0, 0));
    add_row(cmd_row(mk_cmd(CMD_INTEGRATE, 0, 0, 0, 0, 0, 0, 0, 0)));
    add_row(cmd_row(mk_cmd(CMD_INTEGRATE, 4095, 4095, 4095, 4095, 0, 0, 0, 0)));
    add_row(cmd_row(mk_cmd(CMD_INTEGRATE, 0, 0, 4095, 4095, 0, 0, 0, 0)));
    add_row(cmd_row(mk_cmd(CMD_READ, 0, 0, 0, 0, 255, 255, 0, 0)));
    add_row(cfg_row(CFG_ROWS, 16));
    add_row(cfg_row(CFG_COLS, 16));
    add_row(cfg_row(CFG_TRUNC, 1));
    add_row(cfg_row(CFG_FULLW, 0));
    add_row(typed_row(mk_cmd(CMD_INTEGRATE, 257, 0, 0, 0, 0, 0, 0, 0),
                      ST_START_OFF, 0, 0, 0));
    add_row(typed_row(mk_cmd(CMD_INTEGRATE, 0, 0, 0, 300, 0, 0, 0, 0),
                      ST_END_OFF, 0, 0, 0));
    add_row(cmd_row(mk_cmd(CMD_INTEGRATE, 256, 256, 100, 50, 0, 0, 0, 0)));
    add_row(cfg_row(CFG_TRUNC, 4095));
    add_row(cfg_row(CFG_FULLW, 4094));
    add_row(cfg_row(CFG_ROWS, 512));  // masks to zero rows
    add_row(typed_row(mk_cmd(CMD_INTEGRATE, 0, 0, 0, 0, 0, 0, 0, 0), ST_OK, 0, 0, 0));
    add_row(typed_row(mk_cmd(CMD_INTEGRATE, 0, 1, 0, 0, 0, 0, 0, 0),
                      ST_START_OFF, 0, 0, 0));
    add_row(cfg_row(CFG_ROWS, 300));  // beyond the grid
    add_row(cfg_row(CFG_COLS, 511));
    add_row(cfg_row(CFG_TRUNC, 80));
    add_row(cmd_row(mk_cmd(CMD_INTEGRATE, 2000, 100, 2100, 40, 0, 0, 0, 0)));
    add_row(cmd_row(mk_cmd(CMD_READ, 0, 0, 0, 0, 6, 127, 0, 0)));

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_tbl[i]) begin
      if (dir_tbl[i].is_cfg) begin
        drain_block();
        write_reg(dir_tbl[i].idx, dir_tbl[i].val);
      end else begin
        send_cmd(dir_tbl[i].cmd, dir_tbl[i].typed, dir_tbl[i].res);
      end
    end

    // Random phases, each with its own idling mix and register setting
    for (p = 0; p < 4; p++) begin
      drain_block();
      sel = $urandom_range(2);
      write_reg(CFG_TRUNC, (sel == 0) ? 4095 : ((sel == 1) ? 1 : $urandom_range(1, 160)));
      write_reg(CFG_FULLW, $urandom_range(0, (trunc_lim > 4086) ? 4094 : trunc_lim + 8));
      sel = $urandom_range(9);
      write_reg(CFG_ROWS, (sel < 5) ? $urandom_range(1, 24) : ((sel < 8) ? 256 : 257));
      write_reg(CFG_COLS, (sel < 5) ? $urandom_range(1, 24) : ((sel < 8) ? 256 : 300));
      case (p)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
          recv_hold <= 3000;  // output held off while commands keep coming
        end
        1: begin
          send_idle_pct = 84;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 84;
        end
        default: begin
          send_idle_pct = 30;
          recv_stall_pct = 30;
        end
      endcase
      for (k = 0; k < 68; k++) send_cmd(rand_cmd(), 1'b0, '0);
    end

    drain_block();
    repeat (100) @(posedge clk);
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run (clearing pass included)
  initial begin
    #50_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
